>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CMD_W      = 2;
  localparam int PRIO_W     = 16;
  localparam int TARGET_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int OUT_ID_W   = 16;
  localparam int OUT_CNT_W  = 5;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_t;

endpackage

>>> hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes an item, runs one queue operation, holds the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::ctl_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready    = (state == S_IDLE);
  assign ctl.capture = in_valid && in_ready;
  assign ctl.execute = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.capture) begin
            state <= S_EXEC;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (ctl.execute) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Slot array with parallel compare and shift, id counter and result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spq_pkg::ctl_t                       ctl,
  input  logic        [spq_pkg::CMD_W-1:0]    command,
  input  logic signed [spq_pkg::PRIO_W-1:0]   priority_req,
  input  logic        [spq_pkg::TARGET_W-1:0] target_id,
  output logic        [spq_pkg::STATUS_W-1:0] status,
  output logic        [spq_pkg::OUT_ID_W-1:0] entry_id,
  output logic signed [spq_pkg::PRIO_W-1:0]   entry_priority,
  output logic        [spq_pkg::OUT_CNT_W-1:0] entry_count
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (ID_BITS > spq_pkg::TARGET_W) ? ID_BITS : spq_pkg::TARGET_W;
  localparam int WID_W = (CMP_W > spq_pkg::OUT_ID_W) ? CMP_W : spq_pkg::OUT_ID_W;

  logic        [spq_pkg::CMD_W-1:0]    cmd_q;
  logic signed [spq_pkg::PRIO_W-1:0]   prio_q;
  logic        [spq_pkg::TARGET_W-1:0] target_q;

  logic        [ID_BITS-1:0]         slot_id        [QUEUE_DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] slot_prio      [QUEUE_DEPTH];
  logic        [ID_BITS-1:0]         slot_id_next   [QUEUE_DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] slot_prio_next [QUEUE_DEPTH];
  logic        [CNT_W-1:0]           count;
  logic        [CNT_W-1:0]           count_next;
  logic        [ID_BITS-1:0]         next_id;
  logic        [ID_BITS-1:0]         next_id_next;
  logic        [ID_BITS-1:0]         id_inc;

  logic [QUEUE_DEPTH-1:0] slot_valid;
  logic [QUEUE_DEPTH-1:0] stay;
  logic [QUEUE_DEPTH-1:0] ins_here;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] pick;
  logic [QUEUE_DEPTH-1:0] first;
  logic [QUEUE_DEPTH-1:0] seen;
  logic                   found;
  logic                   full;

  logic        [ID_BITS-1:0]         pick_id;
  logic signed [spq_pkg::PRIO_W-1:0] pick_prio;

  logic        [spq_pkg::STATUS_W-1:0] res_status_next;
  logic        [ID_BITS-1:0]           res_id_raw;
  logic        [WID_W-1:0]             res_id_wide;
  logic signed [spq_pkg::PRIO_W-1:0]   res_prio_next;

  // per-slot compares
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_valid[i] = CNT_W'(i) < count;
      stay[i]       = slot_valid[i] && (slot_prio[i] >= prio_q);
      match[i]      = slot_valid[i] && (CMP_W'(slot_id[i]) == CMP_W'(target_q));
    end
  end

  assign ins_here = ~stay & {stay[QUEUE_DEPTH-2:0], 1'b1};
  assign pick     = (cmd_q == spq_pkg::CMD_POP) ? QUEUE_DEPTH'(slot_valid[0]) : match;
  assign first    = pick & (~pick + 1'b1);
  assign seen     = ~(first - 1'b1);
  assign found    = |pick;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign id_inc   = next_id + 1'b1;

  always_comb begin
    pick_id   = '0;
    pick_prio = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first[i]) begin
        pick_id   = pick_id | slot_id[i];
        pick_prio = pick_prio | slot_prio[i];
      end
    end
  end

  always_comb begin
    slot_id_next    = slot_id;
    slot_prio_next  = slot_prio;
    count_next      = count;
    next_id_next    = next_id;
    res_status_next = spq_pkg::ST_MISS;
    res_id_raw      = '0;
    res_prio_next   = '0;
    case (cmd_q) inside
      spq_pkg::CMD_INSERT: begin
        if (full) begin
          res_status_next = spq_pkg::ST_FULL;
        end else begin
          if (ins_here[0]) begin
            slot_id_next[0]   = next_id;
            slot_prio_next[0] = prio_q;
          end
          for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (ins_here[i]) begin
              slot_id_next[i]   = next_id;
              slot_prio_next[i] = prio_q;
            end else if (!stay[i]) begin
              slot_id_next[i]   = slot_id[i-1];
              slot_prio_next[i] = slot_prio[i-1];
            end
          end
          count_next      = count + 1'b1;
          next_id_next    = (id_inc == '0) ? ID_BITS'(1) : id_inc;
          res_status_next = spq_pkg::ST_OK;
          res_id_raw      = next_id;
          res_prio_next   = prio_q;
        end
      end
      spq_pkg::CMD_POP, spq_pkg::CMD_REMOVE: begin
        if (found) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (seen[i]) begin
              slot_id_next[i]   = slot_id[i+1];
              slot_prio_next[i] = slot_prio[i+1];
            end
          end
          count_next      = count - 1'b1;
          res_status_next = spq_pkg::ST_OK;
          res_id_raw      = pick_id;
          res_prio_next   = pick_prio;
        end
      end
      default: begin
        res_status_next = spq_pkg::ST_MISS;
      end
    endcase
  end

  assign res_id_wide = WID_W'(res_id_raw);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= command;
      prio_q   <= priority_req;
      target_q <= target_id;
    end
    if (ctl.execute) begin
      slot_id        <= slot_id_next;
      slot_prio      <= slot_prio_next;
      status         <= res_status_next;
      entry_id       <= res_id_wide[spq_pkg::OUT_ID_W-1:0];
      entry_priority <= res_prio_next;
      entry_count    <= spq_pkg::OUT_CNT_W'(count_next);
    end
    if (rst) begin
      count   <= '0;
      next_id <= ID_BITS'(1);
    end else if (ctl.execute) begin
      count   <= count_next;
      next_id <= next_id_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != '0)
    else $error("id counter holds zero");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (ctl.execute && cmd_q == spq_pkg::CMD_INSERT && !full) |=>
      (count == $past(count) + 1'b1))
    else $error("insert did not add one entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (ctl.execute && res_status_next == spq_pkg::ST_FULL) |-> full)
    else $error("full status while room remains");
`endif

endmodule

>>> hw/rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted priority queue, first in first out within equal priority,
// with pop of the head and removal by id.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   command, priority_req, target_id
//  out      out_valid / out_ready status, entry_id, entry_priority, entry_count
//
//  one item at a time: accept, then an execute state that compares all slots
//  in parallel and shifts the slot array into place
//  the result register frees the input: a new item is taken while a result waits
//  a stalled output holds the operation until the result register is free
//  reset empties the queue and sets the id counter to 1; slot contents are not reset
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [spq_pkg::CMD_W-1:0]     command,
  input  logic signed [spq_pkg::PRIO_W-1:0]    priority_req,
  input  logic        [spq_pkg::TARGET_W-1:0]  target_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [spq_pkg::STATUS_W-1:0]  status,
  output logic        [spq_pkg::OUT_ID_W-1:0]  entry_id,
  output logic signed [spq_pkg::PRIO_W-1:0]    entry_priority,
  output logic        [spq_pkg::OUT_CNT_W-1:0] entry_count
);

  spq_pkg::ctl_t ctl;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .command        (command),
    .priority_req   (priority_req),
    .target_id      (target_id),
    .status         (status),
    .entry_id       (entry_id),
    .entry_priority (entry_priority),
    .entry_count    (entry_count)
  );

endmodule
